// File: hw/rtl/ps2mt_pkg.sv
package ps2mt_pkg;

   // cursor coordinate width and derived arithmetic widths
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int SUM_W = COORD_BITS + 2;
   localparam int LIM_W = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;
   localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

   // packet header bit positions
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SYNC   = 3;
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;
   localparam int HDR_X_OVF  = 6;
   localparam int HDR_Y_OVF  = 7;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_FOUR_BYTE_MODE = 2'd0,
      REG_SCREEN_WIDTH   = 2'd1,
      REG_SCREEN_HEIGHT  = 2'd2
   } reg_index_type;

   // completed packet handed from the assembler to the cursor unit
   typedef struct packed {
      logic       done;
      logic [7:0] header;
      logic [7:0] dx_byte;
      logic [7:0] dy_byte;
   } pkt_type;

endpackage

// File: hw/rtl/ps2mt_channels.sv
// input channel: one controller byte per word
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic       from_aux;
   logic [7:0] data_byte;

   modport source (output valid, output from_aux, output data_byte, input ready);
   modport sink   (input valid, input from_aux, input data_byte, output ready);
endinterface

// result channel: cursor position and buttons per word
interface ps2mt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ps2mt_pkg::COORD_BITS-1:0] cursor_x;
   logic [ps2mt_pkg::COORD_BITS-1:0] cursor_y;
   logic                             left_pressed;
   logic                             right_pressed;
   logic                             middle_pressed;

   modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                   output right_pressed, output middle_pressed, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                   input right_pressed, input middle_pressed, output ready);
endinterface

// File: hw/rtl/ps2mt_assembler.sv
module ps2mt_assembler (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                four_byte_mode,
   input  logic [7:0]          data_byte,
   output ps2mt_pkg::pkt_type  pkt
);

   logic [1:0] byte_index_ff, byte_index_in;
   logic       discard_ff, discard_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] dx_ff, dx_in;
   logic [7:0] dy_ff, dy_in;
   logic [1:0] index_wrap;
   logic       sync_ok;

   // store the byte in its slot; the fourth (wheel) byte is not tracked
   always_comb begin
      header_in = header_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      case (byte_index_ff)
         2'd0:    header_in = data_byte;
         2'd1:    dx_in     = data_byte;
         2'd2:    dy_in     = data_byte;
         default: ;
      endcase
   end

   // advance the index modulo the packet length
   always_comb begin
      if (four_byte_mode) begin
         index_wrap = byte_index_ff + 2'd1;
      end else begin
         case (byte_index_ff)
            2'd2:    index_wrap = 2'd0;
            2'd3:    index_wrap = 2'd1;
            default: index_wrap = byte_index_ff + 2'd1;
         endcase
      end
   end

   assign sync_ok = header_in[ps2mt_pkg::HDR_SYNC];

   // next state: a discarded byte only clears the flag, lost sync restarts
   always_comb begin
      byte_index_in = byte_index_ff;
      discard_in    = discard_ff;
      if (discard_ff) begin
         discard_in = 1'b0;
      end else if (!sync_ok) begin
         discard_in    = 1'b1;
         byte_index_in = 2'd0;
      end else begin
         byte_index_in = index_wrap;
      end
   end

   // packet complete and usable
   always_comb begin
      pkt.header  = header_in;
      pkt.dx_byte = dx_in;
      pkt.dy_byte = dy_in;
      pkt.done    = !discard_ff && sync_ok && (index_wrap == 2'd0) &&
                    !header_in[ps2mt_pkg::HDR_X_OVF] && !header_in[ps2mt_pkg::HDR_Y_OVF];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 2'd0;
         discard_ff    <= 1'b0;
         header_ff     <= 8'd0;
         dx_ff         <= 8'd0;
         dy_ff         <= 8'd0;
      end else if (step) begin
         byte_index_ff <= byte_index_in;
         discard_ff    <= discard_in;
         if (!discard_ff) begin
            header_ff <= header_in;
            dx_ff     <= dx_in;
            dy_ff     <= dy_in;
         end
      end
   end

   // a pending discard always follows an index restart
   a_discard_idx: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> byte_index_ff == 2'd0)
      else $error("discard pending with nonzero byte index");

   // a finished packet leaves the index at the packet start
   a_done_idx: assert property (@(posedge clock) disable iff (reset)
      step && pkt.done |=> byte_index_ff == 2'd0 && !discard_ff)
      else $error("packet completed but index not back at start");

endmodule

// File: hw/rtl/ps2mt_cursor.sv
module ps2mt_cursor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  ps2mt_pkg::pkt_type                  pkt,
   input  logic [ps2mt_pkg::SIZE_BITS-1:0]     screen_width,
   input  logic [ps2mt_pkg::SIZE_BITS-1:0]     screen_height,
   output logic [ps2mt_pkg::COORD_BITS-1:0]    next_x,
   output logic [ps2mt_pkg::COORD_BITS-1:0]    next_y,
   output logic [2:0]                          next_buttons
);

   localparam int C = ps2mt_pkg::COORD_BITS;
   localparam int SW = ps2mt_pkg::SUM_W;
   localparam int LW = ps2mt_pkg::LIM_W;
   localparam int CW = ps2mt_pkg::CMP_W;

   logic [C-1:0]         pos_x_ff, pos_y_ff;
   logic [2:0]           buttons_ff;
   logic signed [8:0]    dx, dy;
   logic signed [SW-1:0] sum_x, sum_y;

   // clamp a signed position to 0 .. min(max(size,1), 2^C) - 1
   function automatic logic [C-1:0] clamp_axis(input logic signed [SW-1:0] v,
                                                 input logic [ps2mt_pkg::SIZE_BITS-1:0] size);
      logic [LW-1:0] eff;
      logic [LW-1:0] lim;
      eff = (size == '0) ? LW'(1) : LW'(size);
      if (eff > (LW'(1) << C)) eff = LW'(1) << C;
      lim = eff - LW'(1);
      if (v < 0)
         clamp_axis = '0;
      else if (CW'($unsigned(v)) > CW'(lim))
         clamp_axis = lim[C-1:0];
      else
         clamp_axis = v[C-1:0];
   endfunction

   // 9-bit deltas, X added and Y subtracted
   assign dx    = {pkt.header[ps2mt_pkg::HDR_X_SIGN], pkt.dx_byte};
   assign dy    = {pkt.header[ps2mt_pkg::HDR_Y_SIGN], pkt.dy_byte};
   assign sum_x = SW'(signed'({1'b0, pos_x_ff})) + SW'(dx);
   assign sum_y = SW'(signed'({1'b0, pos_y_ff})) - SW'(dy);

   assign next_x       = clamp_axis(sum_x, screen_width);
   assign next_y       = clamp_axis(sum_y, screen_height);
   assign next_buttons = pkt.header[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         buttons_ff <= 3'd0;
      end else if (step && pkt.done) begin
         pos_x_ff   <= next_x;
         pos_y_ff   <= next_y;
         buttons_ff <= next_buttons;
      end
   end

   // buttons register mirrors the last accepted header
   a_buttons: assert property (@(posedge clock) disable iff (reset)
      step && pkt.done |=> buttons_ff == $past(pkt.header[2:0]))
      else $error("button state not taken from packet header");

endmodule

// File: hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder with cursor tracker.
// req_ch carries one controller byte per word (from_aux, data_byte); bytes
// with from_aux low are dropped. Mouse bytes are gathered into 3-byte
// packets, or 4-byte packets when four_byte_mode is set. A header without
// its sync bit restarts assembly and drops the following mouse byte. Each
// complete packet without overflow moves the cursor, clamps it to the
// screen and puts one word on rsp_ch with position and buttons.
// csr_we/csr_index/csr_wdata write four_byte_mode, screen_width and
// screen_height; write them only while no byte is in flight.
// Throughput: one byte per cycle while rsp_ch does not stall. One input
// register and one output register: a byte waits in the input register
// while it is decoded, and its result word is loaded into the output one;
// the cursor state updates along with it, so back-to-back bytes chain with no bubble.
// Reset clears the packet state, centers nothing: cursor at 0,0, buttons
// released, width 1024, height 768, three-byte packets.
// When rsp_ch stalls, the output word holds, the input register fills and
// req_ch.ready drops until the word is taken.
module ps2_mouse_packet_cursor_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   ps2mt_req_if.sink                             req_ch,
   ps2mt_rsp_if.source                           rsp_ch,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [ps2mt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int C = ps2mt_pkg::COORD_BITS;

   logic                               four_byte_mode_ff;
   logic [ps2mt_pkg::SIZE_BITS-1:0]    screen_width_ff, screen_height_ff;
   logic                               s1_valid_ff, s1_aux_ff;
   logic [7:0]                         s1_byte_ff;
   logic                               advance, step;
   ps2mt_pkg::pkt_type                 pkt;
   logic [C-1:0]                       next_x, next_y;
   logic [2:0]                         next_buttons;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]                       rsp_x_ff, rsp_y_ff;
   logic [2:0]                         rsp_buttons_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         four_byte_mode_ff <= 1'b0;
         screen_width_ff   <= ps2mt_pkg::SIZE_BITS'(1024);
         screen_height_ff  <= ps2mt_pkg::SIZE_BITS'(768);
      end else if (csr_we) begin
         unique case (ps2mt_pkg::reg_index_type'(csr_index))
            ps2mt_pkg::REG_FOUR_BYTE_MODE: four_byte_mode_ff <= csr_wdata[0];
            ps2mt_pkg::REG_SCREEN_WIDTH:   screen_width_ff   <= csr_wdata;
            ps2mt_pkg::REG_SCREEN_HEIGHT:  screen_height_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: decode moves when the output register is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign step         = advance && s1_aux_ff;
   assign req_ch.ready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_aux_ff  <= req_ch.from_aux;
         s1_byte_ff <= req_ch.data_byte;
      end
   end

   ps2mt_assembler u_assembler (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .four_byte_mode (four_byte_mode_ff),
      .data_byte      (s1_byte_ff),
      .pkt            (pkt)
   );

   ps2mt_cursor u_cursor (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .pkt           (pkt),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .next_x        (next_x),
      .next_y        (next_y),
      .next_buttons  (next_buttons)
   );

   // output register
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || (step && pkt.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && pkt.done) begin
         rsp_x_ff       <= next_x;
         rsp_y_ff       <= next_y;
         rsp_buttons_ff <= next_buttons;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cursor_x       = rsp_x_ff;
   assign rsp_ch.cursor_y       = rsp_y_ff;
   assign rsp_ch.left_pressed   = rsp_buttons_ff[ps2mt_pkg::HDR_LEFT];
   assign rsp_ch.right_pressed  = rsp_buttons_ff[ps2mt_pkg::HDR_RIGHT];
   assign rsp_ch.middle_pressed = rsp_buttons_ff[ps2mt_pkg::HDR_MIDDLE];

   // a new result only appears after a decode step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && pkt.done))
      else $error("result word without a completed packet");

   // a held input byte is never decoded while the output is stalled
   a_no_decode_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !advance)
      else $error("decode while output register is stalled");

endmodule
